[src/mbp_pkg.sv]
package mbp_pkg;

    // Field widths of the item and result channels
    localparam int DATA_W     = 32;
    localparam int COUNT_W    = 6;
    localparam int CAP_W      = 17;
    localparam int ADDR_OUT_W = 16;
    localparam int TOTAL_W    = 32;
    localparam int PEND_W     = 7;
    localparam int PCNT_W     = 3;
    localparam int MAX_BYTES  = 4;
    localparam int NB_W       = 3;
    localparam int ACC_W      = DATA_W + PEND_W;
    localparam int ALIGN_W    = 40;

    // Packed stream widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    localparam int ADDR_BITS_DEFAULT = 16;

    localparam logic [CAP_W-1:0]   CAP_RESET = 17'h10000;
    localparam logic [COUNT_W-1:0] MAX_PUT   = 6'd32;

    // Operation codes
    localparam logic [1:0] FUNC_PUT     = 2'd0;
    localparam logic [1:0] FUNC_FINISH  = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    // Everything the output side needs for one item
    typedef struct packed {
        logic [NB_W-1:0]                  n_written;
        logic [MAX_BYTES-1:0][7:0]        bytes;
        logic [ADDR_OUT_W-1:0]            base_addr;
        logic [TOTAL_W-1:0]               total;
        logic                             overflow;
    } mbp_bundle_t;

endpackage

[src/mbp_calc.sv]
module mbp_calc import mbp_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic [1:0]            func,
    input  logic [DATA_W-1:0]     put_data,
    input  logic [COUNT_W-1:0]    put_count,
    input  logic                  clear_pending,
    input  logic [CAP_W-1:0]      capacity,
    input  logic [PEND_W-1:0]     pending,
    input  logic [PCNT_W-1:0]     pcount,
    input  logic [ADDR_BITS:0]    offset,
    input  logic [TOTAL_W-1:0]    total,
    input  logic                  ovf,
    output logic [PEND_W-1:0]     pending_next,
    output logic [PCNT_W-1:0]     pcount_next,
    output logic [ADDR_BITS:0]    offset_next,
    output logic [TOTAL_W-1:0]    total_next,
    output logic                  ovf_next,
    output mbp_bundle_t           bundle
);

    localparam int OFF_W = ADDR_BITS + 1;
    localparam int CMP_W = (OFF_W > CAP_W) ? OFF_W : CAP_W;

    logic [COUNT_W-1:0] n_put;
    logic [COUNT_W-1:0] n_eff;
    logic [DATA_W:0]    put_mask;
    logic [DATA_W-1:0]  data_eff;
    logic               active;
    logic [ACC_W-1:0]   acc;
    logic [COUNT_W-1:0] cnt;
    logic [ALIGN_W-1:0] aligned;
    logic [NB_W-1:0]    nb;
    logic [7:0]         left_mask;
    logic [CMP_W-1:0]   top;
    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_lim;
    logic [CMP_W-1:0]   off_ext;
    logic [CMP_W-1:0]   room;
    logic [NB_W-1:0]    w;

    // Saturate the count and mask the unused data bits
    assign n_put    = (put_count > MAX_PUT) ? MAX_PUT : put_count;
    assign put_mask = ((DATA_W+1)'(1) << n_put) - (DATA_W+1)'(1);

    // Finish acts as a put of zero bits up to the byte boundary
    always_comb begin
        n_eff    = n_put;
        data_eff = put_data & put_mask[DATA_W-1:0];
        active   = 1'b0;
        unique case (func)
            FUNC_PUT: begin
                active = (n_put != '0);
            end
            FUNC_FINISH: begin
                n_eff    = COUNT_W'(4'd8 - {1'b0, pcount});
                data_eff = '0;
                active   = (pcount != '0);
            end
            default: begin
                active = 1'b0;
            end
        endcase
    end

    // Merge pending bits with the new field and left-align for byte picking
    assign acc     = (ACC_W'(pending) << n_eff) | ACC_W'(data_eff);
    assign cnt     = COUNT_W'({3'b0, pcount}) + n_eff;
    assign aligned = {1'b0, acc} << (COUNT_W'(ALIGN_W) - cnt);
    assign nb      = active ? cnt[5:3] : '0;
    assign left_mask = (8'd1 << cnt[2:0]) - 8'd1;

    // Room left below the capacity limit
    assign top     = CMP_W'(1) << ADDR_BITS;
    assign cap_ext = CMP_W'(capacity);
    assign cap_lim = (cap_ext > top) ? top : cap_ext;
    assign off_ext = CMP_W'(offset);
    assign room    = (off_ext < cap_lim) ? (cap_lim - off_ext) : '0;
    assign w       = (room >= CMP_W'(nb)) ? nb : room[NB_W-1:0];

    // Next state
    always_comb begin
        pending_next = pending;
        pcount_next  = pcount;
        offset_next  = offset;
        total_next   = total;
        ovf_next     = ovf;
        unique case (func)
            FUNC_PUT, FUNC_FINISH: begin
                if (active) begin
                    pending_next = acc[PEND_W-1:0] & left_mask[PEND_W-1:0];
                    pcount_next  = cnt[2:0];
                    offset_next  = offset + OFF_W'(w);
                    ovf_next     = ovf | (w != nb);
                    total_next   = (func == FUNC_PUT) ? total + TOTAL_W'(n_put)
                                                      : total + TOTAL_W'(8);
                end
            end
            FUNC_RESTART: begin
                offset_next = '0;
                ovf_next    = 1'b0;
                if (clear_pending) begin
                    pending_next = '0;
                    pcount_next  = '0;
                    total_next   = '0;
                end
            end
            default: begin
                pending_next = pending;
            end
        endcase
    end

    // Result bundle
    always_comb begin
        bundle.n_written = w;
        for (int j = 0; j < MAX_BYTES; j++) begin
            bundle.bytes[j] = aligned[ALIGN_W-1-8*j -: 8];
        end
        bundle.base_addr = off_ext[ADDR_OUT_W-1:0];
        bundle.total     = total_next;
        bundle.overflow  = ovf_next;
    end

endmodule

[src/mbp_drain.sv]
module mbp_drain import mbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  mbp_bundle_t          bundle,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);

    mbp_bundle_t  hold_reg;
    logic         valid_reg;
    logic [1:0]   idx_reg;
    logic [1:0]   last_idx;
    logic         has_byte;
    logic         take;
    logic [7:0]   out_byte;
    logic [ADDR_OUT_W-1:0] out_addr;

    assign has_byte = (hold_reg.n_written != '0);
    assign last_idx = has_byte ? 2'(hold_reg.n_written - NB_W'(1)) : 2'd0;
    assign take     = valid_reg && m_tready;
    assign can_load = !valid_reg || (take && (idx_reg == last_idx));

    // Hold the bundle and step through its results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (take) begin
            if (idx_reg == last_idx) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            hold_reg <= bundle;
        end
    end

    // Zero byte and address when nothing was written
    assign out_byte = has_byte ? hold_reg.bytes[idx_reg] : 8'd0;
    assign out_addr = has_byte ? hold_reg.base_addr + ADDR_OUT_W'(idx_reg) : '0;

    assign m_tvalid = valid_reg;
    assign m_tuser  = has_byte;
    assign m_tlast  = (idx_reg == last_idx);
    assign m_tdata  = {7'd0, hold_reg.overflow, hold_reg.total, out_addr, out_byte};

    a_empty_single : assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !has_byte) |-> m_tlast)
        else $error("item without bytes must give a single result");

    a_keep_going : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("results of an item lost before its last one");

    a_no_overrun : assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (!valid_reg || (m_tready && m_tlast)))
        else $error("new item loaded over pending results");

endmodule

[src/msb_first_bit_packer_core.sv]
// Path: an accepted item is held in the input register until the output hold
// register can load it; its first result is then presented from that register.
// Throughput: one item per cycle while each item yields one result and m_tready
// is high; an item that writes k bytes (k up to 4) holds the output port for k
// results, as the single-result output register drains the per-item byte bundle.
// Reset (aresetn low, synchronous) clears pending bits, offset, bit count,
// overflow flag and both handshake stages, and sets capacity to 65536.
module msb_first_bit_packer_core import mbp_pkg::*; #(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // capacity_bytes
    input  logic                 cfg_wr_en,
    input  logic [CAP_W-1:0]     cfg_wr_data,
    // item input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // put_data[31:0], put_count[37:32], clear_pending[38]
    input  logic [S_TUSER_W-1:0] s_tuser,  // func[1:0]
    // result output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // out_byte[7:0], byte_address[23:8],
                                           // total_bits[55:24], overflow[56]
    output logic                 m_tuser,  // byte_valid[0]
    output logic                 m_tlast
);

    localparam int OFF_W = ADDR_BITS + 1;

    logic                 in_valid_reg;
    logic [1:0]           in_func_reg;
    logic [DATA_W-1:0]    in_data_reg;
    logic [COUNT_W-1:0]   in_count_reg;
    logic                 in_clr_reg;

    logic [CAP_W-1:0]     cap_reg;
    logic [PEND_W-1:0]    pending_reg;
    logic [PCNT_W-1:0]    pcount_reg;
    logic [OFF_W-1:0]     offset_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic                 ovf_reg;

    logic [PEND_W-1:0]    pending_next;
    logic [PCNT_W-1:0]    pcount_next;
    logic [OFF_W-1:0]     offset_next;
    logic [TOTAL_W-1:0]   total_next;
    logic                 ovf_next;

    mbp_bundle_t          bundle;
    logic                 can_load;
    logic                 advance;

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || advance;

    // Capture the incoming item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_func_reg  <= s_tuser;
            in_data_reg  <= s_tdata[DATA_W-1:0];
            in_count_reg <= s_tdata[DATA_W +: COUNT_W];
            in_clr_reg   <= s_tdata[DATA_W+COUNT_W];
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    // Advance packer state when the item moves to the output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            pcount_reg  <= '0;
            offset_reg  <= '0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
        end else if (advance) begin
            pending_reg <= pending_next;
            pcount_reg  <= pcount_next;
            offset_reg  <= offset_next;
            total_reg   <= total_next;
            ovf_reg     <= ovf_next;
        end
    end

    mbp_calc #(
        .ADDR_BITS (ADDR_BITS)
    ) u_calc (
        .func          (in_func_reg),
        .put_data      (in_data_reg),
        .put_count     (in_count_reg),
        .clear_pending (in_clr_reg),
        .capacity      (cap_reg),
        .pending       (pending_reg),
        .pcount        (pcount_reg),
        .offset        (offset_reg),
        .total         (total_reg),
        .ovf           (ovf_reg),
        .pending_next  (pending_next),
        .pcount_next   (pcount_next),
        .offset_next   (offset_next),
        .total_next    (total_next),
        .ovf_next      (ovf_next),
        .bundle        (bundle)
    );

    mbp_drain u_drain (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance),
        .bundle   (bundle),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    a_restart_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_func_reg == FUNC_RESTART) |=> (offset_reg == '0 && !ovf_reg))
        else $error("restart did not clear offset and overflow");

    a_state_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(offset_reg) && $stable(total_reg) && $stable(pcount_reg)))
        else $error("packer state changed without an item");

    a_finish_flush : assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_func_reg == FUNC_FINISH) |=> (pcount_reg == '0))
        else $error("finish left bits pending");

endmodule

[sim/tb_msb_first_bit_packer_core.sv]
module tb_msb_first_bit_packer_core;
    import mbp_pkg::*;

    // func code that the block ignores
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int MAX_WAIT = 6;
    localparam logic [CAP_W-1:0] CAP_TOP = CAP_W'(1 << ADDR_BITS_DEFAULT);

    typedef struct {
        logic                  byte_valid;
        logic [7:0]            out_byte;
        logic [ADDR_OUT_W-1:0] address;
        logic [TOTAL_W-1:0]    total;
        logic                  ovf;
        logic                  last;
    } pack_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CAP_W-1:0]     cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // put_data[31:0], put_count[37:32], clear_pending[38]
    logic [S_TUSER_W-1:0] s_tuser;   // func[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // out_byte[7:0], byte_address[23:8],
                                     // total_bits[55:24], overflow[56]
    logic                 m_tuser;   // byte_valid[0]
    logic                 m_tlast;

    // Packer state as the block should hold it
    logic [CAP_W-1:0]   cap_reg;
    logic [CAP_W-1:0]   wr_off;
    logic [PEND_W-1:0]  pend_bits;
    logic [PCNT_W-1:0]  pend_cnt;
    logic [TOTAL_W-1:0] bit_count;
    logic               ovf_sticky;

    pack_result_t item_bytes[$];
    pack_result_t packed_out_q[$];

    int mismatches   = 0;
    int src_wait_max = MAX_WAIT;
    int snk_wait_max = MAX_WAIT;
    int hold_cycles  = 0;

    msb_first_bit_packer_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int draw_wait(input int mx);
        return (mx == 0) ? 0 : int'($urandom_range(mx, 0));
    endfunction

    function automatic void reset_model();
        cap_reg    = CAP_RESET;
        wr_off     = '0;
        pend_bits  = '0;
        pend_cnt   = '0;
        bit_count  = '0;
        ovf_sticky = 1'b0;
    endfunction

    // Write a byte if the buffer has room, else drop it and flag overflow
    function automatic void place_byte(input logic [7:0] b);
        pack_result_t r;
        logic [CAP_W-1:0] lim;
        lim = (cap_reg > CAP_TOP) ? CAP_TOP : cap_reg;
        if (wr_off < lim) begin
            r.byte_valid = 1'b1;
            r.out_byte   = b;
            r.address    = wr_off[ADDR_OUT_W-1:0];
            r.total      = '0;
            r.ovf        = 1'b0;
            r.last       = 1'b0;
            item_bytes.push_back(r);
            wr_off = wr_off + 1'b1;
        end else begin
            ovf_sticky = 1'b1;
        end
    endfunction

    // Advance the packer state by one item and queue the results it causes
    function automatic void pack_item(input logic [1:0] f, input logic [DATA_W-1:0] d,
                                      input logic [COUNT_W-1:0] cnt, input logic clr);
        logic [63:0] acc;
        int n;
        int c;
        pack_result_t r;
        item_bytes.delete();
        case (f)
            FUNC_PUT: begin
                n = (cnt > MAX_PUT) ? 32 : int'(cnt);
                if (n > 0) begin
                    acc = (64'(pend_bits) << n) | (64'(d) & ((64'd1 << n) - 64'd1));
                    c = int'(pend_cnt) + n;
                    bit_count = bit_count + TOTAL_W'(n);
                    while (c >= 8) begin
                        c = c - 8;
                        place_byte(8'(acc >> c));
                    end
                    pend_bits = PEND_W'(acc & ((64'd1 << c) - 64'd1));
                    pend_cnt  = PCNT_W'(c);
                end
            end
            FUNC_FINISH: begin
                // pad pending bits with zeros up to a whole byte
                if (pend_cnt != 0) begin
                    bit_count = bit_count + 32'd8;
                    place_byte(8'({1'b0, pend_bits} << (8 - int'(pend_cnt))));
                    pend_bits = '0;
                    pend_cnt  = '0;
                end
            end
            FUNC_RESTART: begin
                wr_off     = '0;
                ovf_sticky = 1'b0;
                if (clr) begin
                    pend_bits = '0;
                    pend_cnt  = '0;
                    bit_count = '0;
                end
            end
            default: ;
        endcase
        if (item_bytes.size() == 0) begin
            r = '{default: '0};
            item_bytes.push_back(r);
        end
        foreach (item_bytes[i]) begin
            r       = item_bytes[i];
            r.total = bit_count;
            r.ovf   = ovf_sticky;
            r.last  = (i == item_bytes.size() - 1);
            packed_out_q.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each accepted result with the oldest predicted one
    always @(posedge aclk) begin
        pack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (packed_out_q.size() == 0) begin
                $error("result with no item behind it: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = packed_out_q.pop_front();
                check_field("byte_valid", 32'(want.byte_valid), 32'(m_tuser));
                check_field("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
                check_field("byte_address", 32'(want.address), 32'(m_tdata[23:8]));
                check_field("total_bits", want.total, m_tdata[55:24]);
                check_field("overflow", 32'(want.ovf), 32'(m_tdata[56]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Result side: random stall per result, plus any requested hold-off
    initial begin
        int wait_n;
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            wait_n = draw_wait(snk_wait_max) + hold_cycles;
            hold_cycles = 0;
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Offer one item; valid stays high into the next item when no gap is drawn
    task automatic send_item(input logic [1:0] f, input logic [DATA_W-1:0] d,
                             input logic [COUNT_W-1:0] cnt, input logic clr);
        int gap;
        gap = draw_wait(src_wait_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {1'b0, clr, cnt, d};
        do @(posedge aclk); while (!s_tready);
        pack_item(f, d, cnt, clr);
        @(negedge aclk);
    endtask

    task automatic send_random_item();
        int sel;
        logic [1:0] f;
        logic [COUNT_W-1:0] cnt;
        sel = $urandom_range(99, 0);
        if (sel < 72) begin
            f = FUNC_PUT;
        end else if (sel < 84) begin
            f = FUNC_FINISH;
        end else if (sel < 94) begin
            f = FUNC_RESTART;
        end else begin
            f = FUNC_UNUSED;
        end
        sel = $urandom_range(19, 0);
        if (sel == 0) begin
            cnt = '0;
        end else if (sel == 1) begin
            cnt = COUNT_W'($urandom_range(63, 33));
        end else begin
            cnt = COUNT_W'($urandom_range(32, 1));
        end
        send_item(f, $urandom, cnt, 1'($urandom_range(1, 0)));
    endtask

    // Drop valid and wait until every predicted result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (packed_out_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = value;
    endtask

    task automatic test_directed_items();
        send_item(FUNC_PUT, 32'hFFFF_FFFF, 6'd32, 1'b0);    // four full bytes
        send_item(FUNC_PUT, 32'h0000_0000, 6'd32, 1'b0);
        send_item(FUNC_PUT, 32'h0000_0005, 6'd3, 1'b0);     // leave bits pending
        send_item(FUNC_PUT, 32'hFFFF_FFFF, 6'd0, 1'b0);     // zero count
        send_item(FUNC_PUT, 32'hDEAD_BEEF, 6'd63, 1'b0);    // count saturates
        send_item(FUNC_PUT, 32'hFFFF_FFFF, 6'd1, 1'b0);     // upper bits ignored
        send_item(FUNC_FINISH, 32'hFFFF_FFFF, 6'd63, 1'b1); // pad pending bits
        send_item(FUNC_FINISH, 32'h0, 6'd0, 1'b0);          // nothing pending
        send_item(FUNC_PUT, 32'h0000_0001, 6'd7, 1'b0);
        send_item(FUNC_RESTART, 32'hFFFF_FFFF, 6'd32, 1'b0); // keep pending bits
        send_item(FUNC_PUT, 32'h0000_0001, 6'd1, 1'b0);
        send_item(FUNC_PUT, 32'h0000_0003, 6'd5, 1'b0);
        send_item(FUNC_RESTART, 32'h0, 6'd0, 1'b1);         // clear everything
        send_item(FUNC_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b1);
        send_item(FUNC_PUT, 32'h8000_0001, 6'd33, 1'b1);
        send_item(FUNC_PUT, 32'h0000_00A5, 6'd8, 1'b0);
        send_item(FUNC_FINISH, 32'h0, 6'd0, 1'b0);
    endtask

    task automatic test_buffer_full();
        set_capacity(17'd0);
        send_item(FUNC_RESTART, 32'h0, 6'd0, 1'b1);
        send_item(FUNC_PUT, 32'h0000_ABCD, 6'd16, 1'b0);    // both bytes dropped
        send_item(FUNC_PUT, 32'h0000_0003, 6'd2, 1'b0);
        send_item(FUNC_FINISH, 32'h0, 6'd0, 1'b0);          // padded byte dropped
        send_item(FUNC_RESTART, 32'h0, 6'd0, 1'b0);         // overflow clears
        set_capacity(17'd2);
        send_item(FUNC_PUT, 32'h1234_5678, 6'd32, 1'b0);    // two kept, two dropped
        send_item(FUNC_PUT, 32'h0000_005A, 6'd8, 1'b0);
        send_item(FUNC_RESTART, 32'h0, 6'd0, 1'b0);
        send_item(FUNC_PUT, 32'h0000_01FF, 6'd9, 1'b0);
        send_item(FUNC_FINISH, 32'h0, 6'd0, 1'b0);
    endtask

    task automatic run_phase(input logic [CAP_W-1:0] cap, input int src_max,
                             input int snk_max, input int n_items);
        set_capacity(cap);
        src_wait_max = src_max;
        snk_wait_max = snk_max;
        send_item(FUNC_RESTART, $urandom, COUNT_W'($urandom_range(63, 0)), 1'b1);
        repeat (n_items) send_random_item();
    endtask

    task automatic test_random_phases();
        run_phase(CAP_RESET, MAX_WAIT, MAX_WAIT, 60);
        run_phase(17'h1FFFF, 0, 0, 40);
        run_phase(17'd7, MAX_WAIT, 0, 40);
        run_phase(17'd0, 0, MAX_WAIT, 20);
        run_phase(17'd23, MAX_WAIT, MAX_WAIT, 60);
    endtask

    // Hold the result side off while items keep coming, so the input stalls
    task automatic test_input_stall();
        set_capacity(CAP_RESET);
        src_wait_max = 0;
        snk_wait_max = 2;
        send_item(FUNC_RESTART, 32'h0, 6'd0, 1'b1);
        hold_cycles = 200;
        repeat (40) send_random_item();
        src_wait_max = MAX_WAIT;
        snk_wait_max = MAX_WAIT;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        reset_model();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_items();
        test_buffer_full();
        test_random_phases();
        test_input_stall();
        settle();
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("msb_first_bit_packer_core regression: pass");
        end else begin
            $display("msb_first_bit_packer_core regression: fail");
        end
        $finish;
    end

    // Bound the run in case the handshake hangs
    initial begin
        #2000000;
        $display("msb_first_bit_packer_core regression: fail");
        $finish;
    end

endmodule

[files.f]
src/mbp_pkg.sv
src/mbp_calc.sv
src/mbp_drain.sv
src/msb_first_bit_packer_core.sv
sim/tb_msb_first_bit_packer_core.sv
